### rtl/ppd_pkg.sv
// shared types, register codes and reset values for the ppm pulse train decoder
package ppd_pkg;

  localparam int unsigned TimeW    = 16;
  localparam int unsigned DeltaW   = 11;
  localparam int unsigned IdxW     = 4;
  localparam int unsigned ValueW   = 16;
  localparam int unsigned CountW   = 8;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned MaxChannelsDef = 8;

  localparam logic [TimeW-1:0]  CounterTopRst  = 16'hFFFF;
  localparam logic [TimeW-1:0]  SyncTicksRst   = 16'd4600;
  localparam logic [TimeW-1:0]  GlitchTicksRst = 16'd1400;
  localparam logic [TimeW-1:0]  CenterTicksRst = 16'd3000;
  localparam logic [DeltaW-1:0] ClampDeltaRst  = 11'd1100;

  typedef enum logic [CfgIdxW-1:0] {
    CfgCounterTop  = 3'd0,
    CfgSyncTicks   = 3'd1,
    CfgGlitchTicks = 3'd2,
    CfgCenterTicks = 3'd3,
    CfgClampDelta  = 3'd4
  } cfg_idx_e;

  typedef enum logic {
    KindChannel = 1'b0,
    KindSync    = 1'b1
  } kind_e;

  typedef struct packed {
    logic [TimeW-1:0]  counter_top;
    logic [TimeW-1:0]  sync_ticks;
    logic [TimeW-1:0]  glitch_ticks;
    logic [TimeW-1:0]  center_ticks;
    logic [DeltaW-1:0] clamp_delta;
  } cfg_t;

  typedef struct packed {
    logic                     valid;
    kind_e                    kind;
    logic [IdxW-1:0]          index;
    logic signed [ValueW-1:0] value;
    logic [CountW-1:0]        count;
  } result_t;

endpackage

### rtl/ppm_pulse_train_decoder_core.sv
// top level of the ppm pulse train decoder: input register, decode stage, result register
// Decodes a PPM pulse train from edge capture timestamps. Each beat on the input
// channel is one counter value; the interval to the previous capture (wrapping at
// counter_top) either marks a frame sync gap, is dropped as a glitch, or becomes a
// channel value: clamped to center +/- delta, centered and scaled by ten. Beats that
// are not syncs are also dropped before the first sync and past the channel limit.
// One beat is taken per clock unless the input stalls: a capture sits in the input
// register, then the decode stage updates its state and the result register.
// Throughput is one capture per cycle, set by the state update loop of the decode stage;
// the input stalls only while the result register is full and the output side stalls.
module ppm_pulse_train_decoder_core #(
  parameter int unsigned MaxChannels = ppd_pkg::MaxChannelsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [ppd_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [ppd_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [ppd_pkg::TimeW-1:0]          capture_time_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic                               result_kind_o,
  output logic [ppd_pkg::IdxW-1:0]           channel_index_o,
  output logic signed [ppd_pkg::ValueW-1:0]  channel_value_o,
  output logic [ppd_pkg::CountW-1:0]         frame_sync_count_o
);

  ppd_pkg::cfg_t    cfg;
  ppd_pkg::result_t res;

  logic                      in_vld_q, in_vld_d;
  logic [ppd_pkg::TimeW-1:0] cap_q;
  logic                      in_accept, advance;

  logic                              out_vld_q, out_vld_d;
  logic                              kind_q;
  logic [ppd_pkg::IdxW-1:0]          idx_q;
  logic signed [ppd_pkg::ValueW-1:0] value_q;
  logic [ppd_pkg::CountW-1:0]        count_q;

  ppd_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  ppd_decode #(
    .MaxChannels (MaxChannels)
  ) u_decode (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .advance_i (advance),
    .capture_i (cap_q),
    .result_o  (res)
  );

  // decode moves whenever the input register holds a beat and the result register can take it
  assign advance    = in_vld_q && (!out_vld_q || !out_stall_i);
  assign in_stall_o = in_vld_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_vld_d   = in_accept || (in_vld_q && !advance);

  always_comb begin
    out_vld_d = out_vld_q;
    if (advance) begin
      out_vld_d = res.valid;
    end else if (!out_stall_i) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      cap_q <= capture_time_i;
    end
    if (advance && res.valid) begin
      kind_q  <= res.kind;
      idx_q   <= res.index;
      value_q <= res.value;
      count_q <= res.count;
    end
  end

  assign out_valid_o        = out_vld_q;
  assign result_kind_o      = kind_q;
  assign channel_index_o    = idx_q;
  assign channel_value_o    = value_q;
  assign frame_sync_count_o = count_q;

`ifndef SYNTHESIS
  a_sync_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == ppd_pkg::KindSync
    |-> channel_index_o == '0 && channel_value_o == '0)
    else $error("sync beat carries channel data");

  a_chan_index_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && result_kind_o == ppd_pkg::KindChannel
    |-> 32'(channel_index_o) < MaxChannels)
    else $error("channel index beyond channel limit");

  a_value_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> channel_value_o <= 16'sd20470 && channel_value_o >= -16'sd20470)
    else $error("channel value out of range");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output back-pressure");
`endif

endmodule

### rtl/ppd_cfg_regs.sv
// configuration register file written through the config beat channel
module ppd_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [ppd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [ppd_pkg::CfgDataW-1:0]  cfg_data_i,
  output ppd_pkg::cfg_t                 cfg_o
);

  ppd_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        ppd_pkg::CfgCounterTop:  cfg_d.counter_top  = cfg_data_i;
        ppd_pkg::CfgSyncTicks:   cfg_d.sync_ticks   = cfg_data_i;
        ppd_pkg::CfgGlitchTicks: cfg_d.glitch_ticks = cfg_data_i;
        ppd_pkg::CfgCenterTicks: cfg_d.center_ticks = cfg_data_i;
        ppd_pkg::CfgClampDelta:  cfg_d.clamp_delta  = cfg_data_i[ppd_pkg::DeltaW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.counter_top  <= ppd_pkg::CounterTopRst;
      cfg_q.sync_ticks   <= ppd_pkg::SyncTicksRst;
      cfg_q.glitch_ticks <= ppd_pkg::GlitchTicksRst;
      cfg_q.center_ticks <= ppd_pkg::CenterTicksRst;
      cfg_q.clamp_delta  <= ppd_pkg::ClampDeltaRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### rtl/ppd_decode.sv
// interval, sync/glitch classification, clamp and scale, plus the decoder state
module ppd_decode #(
  parameter int unsigned MaxChannels = ppd_pkg::MaxChannelsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ppd_pkg::cfg_t              cfg_i,
  input  logic                       advance_i,
  input  logic [ppd_pkg::TimeW-1:0]  capture_i,
  output ppd_pkg::result_t           result_o
);

  localparam int unsigned ChanCntW = $clog2(MaxChannels + 1);
  localparam int unsigned DiffW    = ppd_pkg::TimeW + 1;
  localparam int unsigned ClampW   = ppd_pkg::DeltaW + 1;

  logic [ppd_pkg::TimeW-1:0]  last_q, last_d;
  logic [ChanCntW-1:0]        chan_q, chan_d;
  logic                       await_q, await_d;
  logic [ppd_pkg::CountW-1:0] sync_cnt_q, sync_cnt_d;

  logic [ppd_pkg::TimeW-1:0]  gap;
  logic                       is_sync, is_glitch, chan_full;
  logic signed [DiffW-1:0]    diff, delta_s, clamp_full;
  logic signed [ClampW-1:0]   clamped;
  logic signed [ppd_pkg::ValueW-1:0] clamped_ext;

  // the wrap case adds the distance up to counter_top plus one, in 16-bit arithmetic
  always_comb begin
    if (capture_i >= last_q) begin
      gap = capture_i - last_q;
    end else begin
      gap = cfg_i.counter_top - last_q + capture_i + 16'd1;
    end
  end

  assign is_sync   = gap > cfg_i.sync_ticks;
  assign is_glitch = gap < cfg_i.glitch_ticks;
  assign chan_full = chan_q >= ChanCntW'(MaxChannels);

  // clamp on the difference from center, same test as clamping the interval
  assign diff    = $signed({1'b0, gap}) - $signed({1'b0, cfg_i.center_ticks});
  assign delta_s = $signed({{(DiffW - ppd_pkg::DeltaW){1'b0}}, cfg_i.clamp_delta});

  always_comb begin
    if (diff > delta_s) begin
      clamp_full = delta_s;
    end else if (diff < -delta_s) begin
      clamp_full = -delta_s;
    end else begin
      clamp_full = diff;
    end
  end

  assign clamped     = clamp_full[ClampW-1:0];
  assign clamped_ext = ppd_pkg::ValueW'(clamped);

  always_comb begin
    last_d     = last_q;
    chan_d     = chan_q;
    await_d    = await_q;
    sync_cnt_d = sync_cnt_q;

    result_o.valid = 1'b0;
    result_o.kind  = ppd_pkg::KindChannel;
    result_o.index = '0;
    result_o.value = '0;
    result_o.count = sync_cnt_q;

    last_d = capture_i;
    if (is_sync) begin
      await_d        = 1'b0;
      sync_cnt_d     = sync_cnt_q + 8'd1;
      chan_d         = '0;
      result_o.valid = 1'b1;
      result_o.kind  = ppd_pkg::KindSync;
      result_o.count = sync_cnt_d;
    end else if (!is_glitch && !await_q) begin
      if (chan_full) begin
        await_d = 1'b1;
      end else begin
        result_o.valid = 1'b1;
        result_o.index = ppd_pkg::IdxW'(chan_q);
        result_o.value = (clamped_ext <<< 3) + (clamped_ext <<< 1);
        chan_d         = chan_q + ChanCntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q     <= '0;
      chan_q     <= '0;
      await_q    <= 1'b1;
      sync_cnt_q <= '0;
    end else if (advance_i) begin
      last_q     <= last_d;
      chan_q     <= chan_d;
      await_q    <= await_d;
      sync_cnt_q <= sync_cnt_d;
    end
  end

endmodule
